@@ rtl/bpc_pkg.sv @@
package bpc_pkg;

    localparam int unsigned DIV_W = 32;

    localparam logic [1:0] CFG_OSS   = 2'd0;
    localparam logic [1:0] CFG_CAL_A = 2'd1;
    localparam logic [1:0] CFG_CAL_B = 2'd2;
    localparam logic [1:0] CFG_CAL_C = 2'd3;

    localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
    localparam logic signed [31:0] P_COEF_SQ  = 32'sd3038;
    localparam logic signed [31:0] P_COEF_LIN = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET   = 32'sd3791;
    localparam logic [31:0]        B7_SCALE   = 32'd50000;
    localparam logic signed [31:0] B4_OFFSET  = 32'sd32768;

    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } cal_t;

    // item after temperature front, before division
    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic        err;
        logic [15:0] raw_p;
    } tdiv_t;

    // item handed from front to back through the queue
    typedef struct packed {
        logic signed [31:0] b5;
        logic [18:0]        raw_p;
        logic               err;
    } mid_t;

    // unsigned 32-bit quotient, truncating toward zero, one bit per stage
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
    } div_stage_t;

endpackage

@@ rtl/bpc_udiv.sv @@
module bpc_udiv
    import bpc_pkg::*;
#(
    parameter int unsigned PAYLOAD_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIV_W-1:0]     divisor,
    input  logic [PAYLOAD_W-1:0] in_payload,
    input  logic                 advance,
    output logic                 out_valid,
    output logic [DIV_W-1:0]     quotient,
    output logic [PAYLOAD_W-1:0] out_payload
);

    // one quotient bit per stage, stall-able pipeline
    div_stage_t           st_reg [DIV_W+1];
    logic [PAYLOAD_W-1:0] pl_reg [DIV_W+1];
    logic [DIV_W:0]       v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[DIV_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= '{rem: '0, quo: dividend, dvs: divisor};
            pl_reg[0] <= in_payload;
        end
    end

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_stage
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] shr;
        always_comb
        begin
            shr   = {st_reg[i].rem[DIV_W-2:0], st_reg[i].quo[DIV_W-1]};
            trial = {st_reg[i].rem[DIV_W-1], shr} - {1'b0, st_reg[i].dvs};
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (!trial[DIV_W])
                begin
                    st_reg[i+1].rem <= trial[DIV_W-1:0];
                    st_reg[i+1].quo <= {st_reg[i].quo[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    st_reg[i+1].rem <= shr;
                    st_reg[i+1].quo <= {st_reg[i].quo[DIV_W-2:0], 1'b0};
                end
                st_reg[i+1].dvs <= st_reg[i].dvs;
                pl_reg[i+1]     <= pl_reg[i];
            end
        end
    end

    assign out_valid   = v_reg[DIV_W];
    assign quotient    = st_reg[DIV_W].quo;
    assign out_payload = pl_reg[DIV_W];

endmodule

@@ rtl/bpc_front.sv @@
module bpc_front
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cal_t        cal,
    input  logic        in_valid,
    input  logic [15:0] raw_temperature,
    input  logic [18:0] raw_pressure,
    input  logic        advance,
    output logic        out_valid,
    output mid_t        out_item
);

    logic               s1_v_reg;
    logic signed [31:0] s1_prod_reg;
    logic [18:0]        s1_p_reg;
    logic               s2_v_reg;
    logic signed [31:0] s2_x1_reg;
    logic signed [31:0] s2_den_reg;
    logic [18:0]        s2_p_reg;
    logic signed [31:0] mc_sh;

    logic signed [31:0] x1_w;
    logic signed [31:0] den_w;
    logic               neg_q;
    logic [31:0]        num_abs;
    logic [31:0]        den_abs;
    logic               dv_valid;
    logic [31:0]        dv_q;
    logic [31:0]        dv_x1;
    logic [31:0]        x2;
    logic [18:0]        dv_p;
    logic               dv_neg;
    logic               dv_err;

    assign mc_sh = {{5{cal.mc[15]}}, cal.mc, 11'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_reg <= 32'($signed({16'd0, raw_temperature}) - $signed({16'd0, cal.ac6}))
                           * $signed({16'd0, cal.ac5});
            s1_p_reg    <= raw_pressure;
            s2_x1_reg   <= x1_w;
            s2_den_reg  <= den_w;
            s2_p_reg    <= s1_p_reg;
        end
    end

    always_comb
    begin
        x1_w  = s1_prod_reg >>> 15;
        den_w = x1_w + 32'($signed(cal.md));
    end

    always_comb
    begin
        neg_q   = mc_sh[31] ^ s2_den_reg[31];
        num_abs = mc_sh[31] ? 32'(-mc_sh) : mc_sh;
        den_abs = s2_den_reg[31] ? 32'(-s2_den_reg) : s2_den_reg;
    end

    bpc_udiv #(.PAYLOAD_W(32 + 19 + 2)) u_tdiv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_v_reg),
        .dividend   (num_abs),
        .divisor    (den_abs),
        .in_payload ({s2_x1_reg, s2_p_reg, neg_q, (s2_den_reg == 32'sd0)}),
        .advance    (advance),
        .out_valid  (dv_valid),
        .quotient   (dv_q),
        .out_payload({dv_x1, dv_p, dv_neg, dv_err})
    );

    always_comb
    begin
        x2                = dv_neg ? 32'(-dv_q) : dv_q;
        out_valid         = dv_valid;
        out_item.b5       = $signed(dv_x1 + x2);
        out_item.raw_p    = dv_p;
        out_item.err      = dv_err;
    end

endmodule

@@ rtl/bpc_queue.sv @@
module bpc_queue
    import bpc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  mid_t wr_data,
    output logic almost_full,
    input  logic rd_en,
    output logic rd_valid,
    output mid_t rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mid_t          mem_reg [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    assign rd_valid    = (cnt_reg != '0);
    assign rd_data     = mem_reg[rp_reg];
    assign almost_full = (cnt_reg >= (AW+1)'(DEPTH - 1));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH)) |-> !wr_en || rd_en)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> rd_valid)
        else $error("queue underflow");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("count step wrong");
`endif

endmodule

@@ rtl/bpc_back.sv @@
module bpc_back
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cal_t        cal,
    input  logic        in_valid,
    input  mid_t        in_item,
    input  logic        advance,
    output logic        out_valid,
    output logic [31:0] temperature_tenths,
    output logic [31:0] pressure_pa,
    output logic        divide_error
);

    typedef struct packed {
        logic signed [31:0] temp;
        logic               err;
    } side_t;

    // stage a: b6, temp
    logic               a_v_reg;
    logic signed [31:0] a_b6_reg;
    side_t              a_s_reg;
    logic [18:0]        a_p_reg;
    // stage b: products of b6
    logic               b_v_reg;
    logic signed [31:0] b_b6b6_reg;
    logic signed [31:0] b_ac2b6_reg;
    logic signed [31:0] b_ac3b6_reg;
    side_t              b_s_reg;
    logic [18:0]        b_p_reg;
    // stage c: products of sq
    logic               c_v_reg;
    logic signed [31:0] c_b2sq_reg;
    logic signed [31:0] c_b1sq_reg;
    logic signed [31:0] c_x2a_reg;
    logic signed [31:0] c_x1b_reg;
    side_t              c_s_reg;
    logic [18:0]        c_p_reg;
    // stage d: b3, x3 for b4
    logic               d_v_reg;
    logic signed [31:0] d_b3_reg;
    logic signed [31:0] d_x3_reg;
    side_t              d_s_reg;
    logic [18:0]        d_p_reg;
    // stage e: b4, b7
    logic               e_v_reg;
    logic [31:0]        e_b4_reg;
    logic [31:0]        e_b7_reg;
    side_t              e_s_reg;
    // post-divide stages
    logic               f_v_reg;
    logic signed [31:0] f_p_reg;
    logic signed [31:0] f_sq_reg;
    logic signed [31:0] f_lin_reg;
    side_t              f_s_reg;
    logic               g_v_reg;
    logic signed [31:0] g_p_reg;
    logic signed [31:0] g_x1_reg;
    logic signed [31:0] g_lin_reg;
    side_t              g_s_reg;

    logic signed [31:0] sq_w;
    logic signed [31:0] x3p_w;
    logic signed [31:0] b3_w;
    logic signed [31:0] b3sh_w;
    logic signed [31:0] b3r_w;
    logic signed [31:0] x3_w;
    logic [31:0]        b4_w;
    logic [31:0]        b7_w;
    logic               big_w;
    logic [31:0]        dvd_w;
    logic               dv_valid;
    logic [31:0]        dv_q;
    logic               dv_big;
    logic               dv_err;
    logic [31:0]        dv_temp;
    logic [31:0]        q_w;
    logic signed [31:0] p8_w;
    logic signed [31:0] x3f_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= dv_valid;
            g_v_reg <= f_v_reg;
        end
    end

    always_comb
    begin
        sq_w   = b_b6b6_reg >>> 12;
        x3p_w  = (c_b2sq_reg >>> 11) + (c_x2a_reg >>> 11);
        b3_w   = 32'($signed(cal.ac1)) * 4 + x3p_w;
        b3sh_w = b3_w << cal.oss;
        b3r_w  = b3sh_w + 32'sd2;
        // signed divide by four truncating toward zero
        b3r_w  = (b3r_w + (b3r_w[31] ? 32'sd3 : 32'sd0)) >>> 2;
        x3_w   = (((c_x1b_reg >>> 13) + (c_b1sq_reg >>> 16)) + 32'sd2) >>> 2;
        b4_w   = ({16'd0, cal.ac4} * 32'(d_x3_reg + B4_OFFSET)) >> 15;
        b7_w   = 32'($signed({13'd0, d_p_reg}) - d_b3_reg) * (B7_SCALE >> cal.oss);
        big_w  = e_b7_reg[31];
        dvd_w  = big_w ? e_b7_reg : {e_b7_reg[30:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_b6_reg     <= in_item.b5 - B6_OFFSET;
            a_s_reg      <= '{temp: (in_item.b5 + 32'sd8) >>> 4, err: in_item.err};
            a_p_reg      <= in_item.raw_p;
            b_b6b6_reg   <= a_b6_reg * a_b6_reg;
            b_ac2b6_reg  <= 32'($signed(cal.ac2)) * a_b6_reg;
            b_ac3b6_reg  <= 32'($signed(cal.ac3)) * a_b6_reg;
            b_s_reg      <= a_s_reg;
            b_p_reg      <= a_p_reg;
            c_b2sq_reg   <= 32'($signed(cal.b2)) * sq_w;
            c_b1sq_reg   <= 32'($signed(cal.b1)) * sq_w;
            c_x2a_reg    <= b_ac2b6_reg;
            c_x1b_reg    <= b_ac3b6_reg;
            c_s_reg      <= b_s_reg;
            c_p_reg      <= b_p_reg;
            d_b3_reg     <= b3r_w;
            d_x3_reg     <= x3_w;
            d_s_reg      <= c_s_reg;
            d_p_reg      <= c_p_reg;
            e_b4_reg     <= b4_w;
            e_b7_reg     <= b7_w;
            e_s_reg      <= d_s_reg;
        end
    end

    bpc_udiv #(.PAYLOAD_W(32 + 2)) u_pdiv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (e_v_reg),
        .dividend   (dvd_w),
        .divisor    (e_b4_reg),
        .in_payload ({e_s_reg.temp, big_w, e_s_reg.err || (e_b4_reg == '0)}),
        .advance    (advance),
        .out_valid  (dv_valid),
        .quotient   (dv_q),
        .out_payload({dv_temp, dv_big, dv_err})
    );

    always_comb
    begin
        q_w   = dv_big ? {dv_q[30:0], 1'b0} : dv_q;
        p8_w  = $signed(q_w) >>> 8;
        x3f_w = (((g_x1_reg * P_COEF_SQ) >>> 16) + (g_lin_reg >>> 16)) + P_OFFSET;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f_p_reg   <= $signed(q_w);
            f_sq_reg  <= p8_w * p8_w;
            f_lin_reg <= P_COEF_LIN * $signed(q_w);
            f_s_reg   <= '{temp: $signed(dv_temp), err: dv_err};
            g_p_reg   <= f_p_reg;
            g_x1_reg  <= f_sq_reg;
            g_lin_reg <= f_lin_reg;
            g_s_reg   <= f_s_reg;
        end
    end

    assign out_valid          = g_v_reg;
    assign divide_error       = g_s_reg.err;
    assign temperature_tenths = g_s_reg.err ? 32'd0 : g_s_reg.temp;
    assign pressure_pa        = g_s_reg.err ? 32'd0 : 32'(g_p_reg + (x3f_w >>> 4));

endmodule

@@ rtl/barometric_pressure_compensation.sv @@
// throughput: one item per cycle while results are popped; two 32-stage divider
// pipelines set the depth
// the front stalls only when its last stage holds an item and the mid queue is nearly full,
// the back only when its last stage holds a result and the output queue is full
// reset: asynchronous, active low; queues empty, oversampling 3, coefficients zero
module barometric_pressure_compensation
    import bpc_pkg::*;
#(
    parameter int unsigned MID_DEPTH = 4,
    parameter int unsigned OUT_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] raw_temperature,
    input  logic [18:0] raw_pressure,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] temperature_tenths,
    output logic [31:0] pressure_pa,
    output logic        divide_error
);

    localparam int unsigned OAW = $clog2(OUT_DEPTH + 1);
    localparam int unsigned OPW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        err;
    } res_t;

    logic [1:0]  oss_reg;
    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;
    cal_t        cal;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg   <= 2'd3;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OSS:   oss_reg   <= cfg_data[1:0];
                CFG_CAL_A: cal_a_reg <= cfg_data;
                CFG_CAL_B: cal_b_reg <= cfg_data;
                CFG_CAL_C: cal_c_reg <= cfg_data[31:0];
                default:   oss_reg   <= oss_reg;
            endcase
        end
    end

    always_comb
    begin
        cal.ac1 = cal_a_reg[15:0];
        cal.ac2 = cal_a_reg[31:16];
        cal.ac3 = cal_a_reg[47:32];
        cal.ac4 = cal_a_reg[63:48];
        cal.ac5 = cal_b_reg[15:0];
        cal.ac6 = cal_b_reg[31:16];
        cal.b1  = cal_b_reg[47:32];
        cal.b2  = cal_b_reg[63:48];
        cal.mc  = cal_c_reg[15:0];
        cal.md  = cal_c_reg[31:16];
        cal.oss = oss_reg;
    end

    logic           adv_front;
    logic           adv_back;
    logic           accept;
    logic           f_valid;
    mid_t           f_item;
    logic           f_write;
    logic           m_valid;
    mid_t           m_item;
    logic           m_take;
    logic           mid_afull;
    logic           b_valid;
    res_t           b_res;
    logic           o_write;
    logic           o_take;
    logic           ofull;

    // each side freezes only when its finished item waits and the queue after it is nearly full (mid) or full (output)
    assign adv_front = !(f_valid && mid_afull);
    assign full      = !adv_front;
    assign accept    = push && !full;
    assign f_write   = f_valid && adv_front;

    bpc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cal            (cal),
        .in_valid       (accept),
        .raw_temperature(raw_temperature),
        .raw_pressure   (raw_pressure),
        .advance        (adv_front),
        .out_valid      (f_valid),
        .out_item       (f_item)
    );

    bpc_queue #(.DEPTH(MID_DEPTH)) u_mid (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (f_write),
        .wr_data    (f_item),
        .almost_full(mid_afull),
        .rd_en      (m_take),
        .rd_valid   (m_valid),
        .rd_data    (m_item)
    );

    assign m_take = m_valid && adv_back;

    bpc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cal               (cal),
        .in_valid          (m_take),
        .in_item           (m_item),
        .advance           (adv_back),
        .out_valid         (b_valid),
        .temperature_tenths(b_res.temp),
        .pressure_pa       (b_res.pres),
        .divide_error      (b_res.err)
    );

    // output queue
    res_t           obuf_reg [OUT_DEPTH];
    logic [OPW-1:0] owp_reg;
    logic [OPW-1:0] orp_reg;
    logic [OAW-1:0] ocnt_reg;

    assign ofull    = (ocnt_reg == OAW'(OUT_DEPTH));
    assign adv_back = !(b_valid && ofull);
    assign o_write  = b_valid && !ofull;
    assign o_take   = pop && !empty;
    assign empty    = (ocnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= '0;
            orp_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (o_write)
            begin
                owp_reg <= (owp_reg == OPW'(OUT_DEPTH - 1)) ? '0 : owp_reg + 1'b1;
            end
            if (o_take)
            begin
                orp_reg <= (orp_reg == OPW'(OUT_DEPTH - 1)) ? '0 : orp_reg + 1'b1;
            end
            ocnt_reg <= ocnt_reg + OAW'(o_write) - OAW'(o_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_write)
        begin
            obuf_reg[owp_reg] <= b_res;
        end
    end

    always_comb
    begin
        temperature_tenths = obuf_reg[orp_reg].temp;
        pressure_pa        = obuf_reg[orp_reg].pres;
        divide_error       = obuf_reg[orp_reg].err;
    end

`ifndef SYNTHESIS
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        o_write |-> (ocnt_reg != OAW'(OUT_DEPTH)))
        else $error("output buffer overflow");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divide_error) |-> (temperature_tenths == '0) && (pressure_pa == '0))
        else $error("error result not zeroed");
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && !adv_front) |=> f_valid)
        else $error("front item lost while stalled");
    a_back_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid && !adv_back) |=> b_valid)
        else $error("back result lost while stalled");
`endif

endmodule
